[hdl/vfm_pkg.sv]
// ----------------------------------------------------------------------------
// vfm_pkg
// Shared types, constants and lookup tables for the voxel face mesher.
// ----------------------------------------------------------------------------
`default_nettype none

package vfm_pkg;

   localparam int ATLAS_TILES = 4;
   localparam int TEX_REGS    = 7;
   localparam int TEX_W       = 12;
   localparam int ADDR_W      = 5;
   localparam int NUM_FACES   = 6;
   localparam int NUM_VERTS   = 6;

   typedef logic [2:0]  btype_type;
   typedef logic [3:0]  coord_x_type;
   typedef logic [6:0]  coord_y_type;
   typedef logic [3:0]  coord_z_type;
   typedef logic [NUM_FACES-1:0] face_mask_type;
   typedef logic [2:0]  face_type;
   typedef logic [2:0]  vert_idx_type;
   typedef logic [3:0]  tex_idx_type;
   typedef logic [TEX_REGS-1:0][TEX_W-1:0] tex_bank_type;

   localparam btype_type    BT_AIR      = 3'd0;
   localparam face_type     FACE_TOP    = 3'd4;
   localparam face_type     FACE_BOTTOM = 3'd5;
   localparam vert_idx_type LAST_VERT   = 3'd5;

   // corner offsets: bit2 = x, bit1 = y, bit0 = z
   localparam logic [2:0] CORNER_TAB [NUM_FACES][NUM_VERTS] = '{
      '{3'd6, 3'd4, 3'd0, 3'd2, 3'd6, 3'd0},
      '{3'd3, 3'd1, 3'd5, 3'd7, 3'd3, 3'd5},
      '{3'd2, 3'd0, 3'd1, 3'd3, 3'd2, 3'd1},
      '{3'd7, 3'd5, 3'd4, 3'd6, 3'd7, 3'd4},
      '{3'd7, 3'd6, 3'd2, 3'd3, 3'd7, 3'd2},
      '{3'd4, 3'd5, 3'd1, 3'd0, 3'd4, 3'd1}
   };

   // texture corner per vertex: bit1 = u, bit0 = v
   localparam logic [1:0] UV_TAB [NUM_VERTS] = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd0};

   typedef struct packed {
      logic         valid;
      btype_type    btype;
      coord_x_type  lx;
      coord_y_type  ly;
      coord_z_type  lz;
      face_type     face;
      vert_idx_type vert;
      logic         last;
   } vtx_type;

   function automatic face_type first_face(input face_mask_type m);
      face_type f;
      f = '0;
      for (int i = NUM_FACES - 1; i >= 0; i--) begin
         if (m[i]) begin
            f = face_type'(i);
         end
      end
      return f;
   endfunction

   function automatic logic [2:0] corner_of(input face_type f, input vert_idx_type v);
      logic [2:0] c;
      c = '0;
      if (f < face_type'(NUM_FACES) && v < vert_idx_type'(NUM_VERTS)) begin
         c = CORNER_TAB[f][v];
      end
      return c;
   endfunction

   function automatic logic [1:0] uv_of(input vert_idx_type v);
      logic [1:0] uv;
      uv = '0;
      if (v < vert_idx_type'(NUM_VERTS)) begin
         uv = UV_TAB[v];
      end
      return uv;
   endfunction

endpackage

`default_nettype wire

[hdl/vfm_voxel_if.sv]
// ----------------------------------------------------------------------------
// vfm_voxel_if
// Voxel channel: one voxel word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfm_voxel_if;
   logic       valid;
   logic       ready;
   logic [2:0] block_type;
   logic [3:0] local_x;
   logic [6:0] local_y;
   logic [3:0] local_z;
   logic [5:0] air_neighbors;

   modport source (
      output valid, block_type, local_x, local_y, local_z, air_neighbors,
      input  ready
   );
   modport sink (
      input  valid, block_type, local_x, local_y, local_z, air_neighbors,
      output ready
   );
endinterface

`default_nettype wire

[hdl/vfm_vertex_if.sv]
// ----------------------------------------------------------------------------
// vfm_vertex_if
// Vertex channel: one mesh vertex word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfm_vertex_if;
   logic       valid;
   logic       ready;
   logic [4:0] vert_x;
   logic [7:0] vert_y;
   logic [4:0] vert_z;
   logic [2:0] tex_u;
   logic [2:0] tex_v;
   logic [2:0] face_index;
   logic       last_vertex;

   modport source (
      output valid, vert_x, vert_y, vert_z, tex_u, tex_v, face_index, last_vertex,
      input  ready
   );
   modport sink (
      input  valid, vert_x, vert_y, vert_z, tex_u, tex_v, face_index, last_vertex,
      output ready
   );
endinterface

`default_nettype wire

[hdl/vfm_csr.sv]
// ----------------------------------------------------------------------------
// vfm_csr
// APB register bank holding the packed side/top/bottom texture indices.
// ----------------------------------------------------------------------------
`default_nettype none

module vfm_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [vfm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready,
   output vfm_pkg::tex_bank_type           tex
);
   import vfm_pkg::*;

   localparam tex_bank_type TEX_RESET = {
      12'd2184, 12'd1911, 12'd1638, 12'd1093, 12'd819, 12'd18, 12'd0
   };

   logic [ADDR_W-3:0] reg_idx;
   logic              wr_en;
   tex_bank_type      tex_ff;
   tex_bank_type      tex_in;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      tex_in = tex_ff;
      if (wr_en && reg_idx < (ADDR_W-2)'(TEX_REGS)) begin
         tex_in[reg_idx] = pwdata[TEX_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx < (ADDR_W-2)'(TEX_REGS)) begin
         prdata = {{(32-TEX_W){1'b0}}, tex_ff[reg_idx]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_ff <= TEX_RESET;
      end else begin
         tex_ff <= tex_in;
      end
   end

   assign tex = tex_ff;

endmodule

`default_nettype wire

[hdl/vfm_seq.sv]
// ----------------------------------------------------------------------------
// vfm_seq
// Holds the current voxel and walks its visible faces, one vertex per step.
// ----------------------------------------------------------------------------
`default_nettype none

module vfm_seq (
   input  wire logic      clock,
   input  wire logic      reset,
   vfm_voxel_if.sink      req_bus,
   input  wire logic      take,
   output vfm_pkg::vtx_type vtx
);
   import vfm_pkg::*;

   logic          busy_ff,  busy_in;
   face_mask_type pend_ff,  pend_in;
   face_type      face_ff,  face_in;
   vert_idx_type  vert_ff,  vert_in;
   btype_type     btype_ff, btype_in;
   coord_x_type   lx_ff,    lx_in;
   coord_y_type   ly_ff,    ly_in;
   coord_z_type   lz_ff,    lz_in;

   face_mask_type pend_clr;
   logic          last_now;
   logic          accept;
   logic          live;

   // pending faces once the current one is done
   assign pend_clr = pend_ff & ~(face_mask_type'(1) << face_ff);
   assign last_now = (vert_ff == LAST_VERT) && (pend_clr == '0);

   assign req_bus.ready = !busy_ff || (take && last_now);
   assign accept = req_bus.valid && req_bus.ready;
   assign live   = (req_bus.block_type != BT_AIR) && (req_bus.air_neighbors != '0);

   always_comb begin
      busy_in  = busy_ff;
      pend_in  = pend_ff;
      face_in  = face_ff;
      vert_in  = vert_ff;
      btype_in = btype_ff;
      lx_in    = lx_ff;
      ly_in    = ly_ff;
      lz_in    = lz_ff;
      if (busy_ff && take) begin
         if (vert_ff == LAST_VERT) begin
            pend_in = pend_clr;
            face_in = first_face(pend_clr);
            vert_in = '0;
            if (last_now) begin
               busy_in = 1'b0;
            end
         end else begin
            vert_in = vert_ff + 3'd1;
         end
      end
      if (accept) begin
         // air voxels and fully hidden voxels are dropped here
         busy_in  = live;
         pend_in  = req_bus.air_neighbors;
         face_in  = first_face(req_bus.air_neighbors);
         vert_in  = '0;
         btype_in = req_bus.block_type;
         lx_in    = req_bus.local_x;
         ly_in    = req_bus.local_y;
         lz_in    = req_bus.local_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      pend_ff  <= pend_in;
      face_ff  <= face_in;
      vert_ff  <= vert_in;
      btype_ff <= btype_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      lz_ff    <= lz_in;
   end

   always_comb begin
      vtx.valid = busy_ff;
      vtx.btype = btype_ff;
      vtx.lx    = lx_ff;
      vtx.ly    = ly_ff;
      vtx.lz    = lz_ff;
      vtx.face  = face_ff;
      vtx.vert  = vert_ff;
      vtx.last  = last_now;
   end

`ifndef SYNTHESIS
   a_load: assert property (@(posedge clock) disable iff (reset)
      (accept && live) |=> (busy_ff && vert_ff == '0))
      else $error("visible voxel did not start at its first vertex");

   a_face_pending: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pend_ff[face_ff])
      else $error("current face is not among the pending faces");

   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (vert_ff <= LAST_VERT && face_ff <= FACE_BOTTOM))
      else $error("face or vertex counter out of range");

   a_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && !live) |=> !busy_ff)
      else $error("hidden or air voxel started emitting");
`endif

endmodule

`default_nettype wire

[hdl/vfm_emit.sv]
// ----------------------------------------------------------------------------
// vfm_emit
// Builds one vertex (position, atlas coordinates) into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vfm_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vfm_pkg::vtx_type      vtx,
   input  wire vfm_pkg::tex_bank_type tex,
   output logic                       take,
   vfm_vertex_if.source               rsp_bus
);
   import vfm_pkg::*;

   logic        valid_ff;
   logic [4:0]  vx_ff,   vx_in;
   logic [7:0]  vy_ff,   vy_in;
   logic [4:0]  vz_ff,   vz_in;
   logic [2:0]  tu_ff,   tu_in;
   logic [2:0]  tv_ff,   tv_in;
   face_type    face_ff;
   logic        last_ff;

   btype_type   tsel;
   logic [TEX_W-1:0] packed_idx;
   tex_idx_type idx;
   tex_idx_type tcol;
   tex_idx_type trow;
   logic [2:0]  corner;
   logic [1:0]  uv;

   assign take = !valid_ff || rsp_bus.ready;

   assign tsel = vtx.btype - 3'd1;

   always_comb begin
      packed_idx = '0;
      if (tsel < btype_type'(TEX_REGS)) begin
         packed_idx = tex[tsel];
      end
      case (vtx.face)
         FACE_TOP:    idx = packed_idx[7:4];
         FACE_BOTTOM: idx = packed_idx[11:8];
         default:     idx = packed_idx[3:0];
      endcase
   end

   assign tcol   = tex_idx_type'(idx % ATLAS_TILES);
   assign trow   = tex_idx_type'(idx / ATLAS_TILES);
   assign corner = corner_of(vtx.face, vtx.vert);
   assign uv     = uv_of(vtx.vert);

   assign vx_in = 5'({1'b0, vtx.lx} + {4'b0, corner[2]});
   assign vy_in = 8'({1'b0, vtx.ly} + {7'b0, corner[1]});
   assign vz_in = 5'({1'b0, vtx.lz} + {4'b0, corner[0]});
   assign tu_in = 3'(tcol + {3'b0, uv[1]});
   assign tv_in = 3'(trow + {3'b0, uv[0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= vtx.valid;
      end
      if (take && vtx.valid) begin
         vx_ff   <= vx_in;
         vy_ff   <= vy_in;
         vz_ff   <= vz_in;
         tu_ff   <= tu_in;
         tv_ff   <= tv_in;
         face_ff <= vtx.face;
         last_ff <= vtx.last;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.vert_x      = vx_ff;
   assign rsp_bus.vert_y      = vy_ff;
   assign rsp_bus.vert_z      = vz_ff;
   assign rsp_bus.tex_u       = tu_ff;
   assign rsp_bus.tex_v       = tv_ff;
   assign rsp_bus.face_index  = face_ff;
   assign rsp_bus.last_vertex = last_ff;

endmodule

`default_nettype wire

[hdl/voxel_face_mesher.sv]
// ----------------------------------------------------------------------------
// voxel_face_mesher
// Face-culling mesher: one voxel in, six vertices out for each face that
// borders air, with atlas texture coordinates from the per-type registers.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             word
//  req_bus   in    valid/ready           block_type, local_x/y/z, air_neighbors
//  rsp_bus   out   valid/ready           vert_x/y/z, tex_u/v, face_index, last_vertex
//  apb       in    psel/penable/pready   texture registers at 4*i, i = 0..6
//
//  one vertex per cycle unless the result register stalls; a voxel with n visible
//  faces gives 6*n vertices from the face/vertex walker, air/hidden voxels give none
//  the next voxel is taken in the cycle its last vertex enters the result register
//  result register stalls hold the walker; input stalls leave it idle
//  synchronous reset clears the handshake state and loads the texture defaults
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_face_mesher (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [vfm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready,
   vfm_voxel_if.sink                       req_bus,
   vfm_vertex_if.source                    rsp_bus
);
   import vfm_pkg::*;

   tex_bank_type tex;
   vtx_type      vtx;
   logic         take;

   vfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .tex     (tex)
   );

   vfm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .vtx     (vtx)
   );

   vfm_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .vtx     (vtx),
      .tex     (tex),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

[tb/sv/tb_voxel_face_mesher.sv]
// ----------------------------------------------------------------------------
// tb_voxel_face_mesher
// Self-checking bench for the voxel face mesher: voxels go in through a
// randomly idling driver, vertex words come out through a randomly stalling
// sink and are compared field by field with a local prediction of the face
// culling, corner placement and atlas lookup under several texture settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voxel_face_mesher;
   timeunit 1ns;
   timeprecision 1ps;

   import vfm_pkg::*;

   typedef struct packed {
      btype_type     kind;
      coord_x_type   x;
      coord_y_type   y;
      coord_z_type   z;
      face_mask_type open_faces;
   } voxel_type;

   typedef struct packed {
      logic [4:0] x;
      logic [7:0] y;
      logic [4:0] z;
      logic [2:0] u;
      logic [2:0] v;
      face_type   face;
      logic       last;
   } vertex_type;

   localparam btype_type KIND_STONE  = 3'd3;
   localparam btype_type KIND_LOG    = 3'd4;
   localparam btype_type KIND_WATER  = 3'd7;

   // register index past the texture bank, writes there are dropped
   localparam int REG_SPARE     = 7;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_VOXELS  = 58;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [TEX_W-1:0] TEX_DEFAULTS [TEX_REGS] = '{
      12'd0, 12'd18, 12'd819, 12'd1093, 12'd1638, 12'd1911, 12'd2184
   };

   // cube corner per face and vertex: bit2 = x, bit1 = y, bit0 = z
   localparam logic [2:0] CUBE_CORNER [NUM_FACES][NUM_VERTS] = '{
      '{3'd6, 3'd4, 3'd0, 3'd2, 3'd6, 3'd0},
      '{3'd3, 3'd1, 3'd5, 3'd7, 3'd3, 3'd5},
      '{3'd2, 3'd0, 3'd1, 3'd3, 3'd2, 3'd1},
      '{3'd7, 3'd5, 3'd4, 3'd6, 3'd7, 3'd4},
      '{3'd7, 3'd6, 3'd2, 3'd3, 3'd7, 3'd2},
      '{3'd4, 3'd5, 3'd1, 3'd0, 3'd4, 3'd1}
   };
   // tile corner per vertex: bit1 = u, bit0 = v
   localparam logic [1:0] TILE_CORNER [NUM_VERTS] = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd0};

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   vfm_voxel_if  voxel_bus ();
   vfm_vertex_if vertex_bus ();

   voxel_face_mesher u_dut (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .req_bus (voxel_bus),
      .rsp_bus (vertex_bus)
   );

   logic [TEX_W-1:0] tex_bank [TEX_REGS];
   voxel_type        pending_voxels [$];
   vertex_type       expected_verts [$];
   voxel_type        voxel_on_bus;
   logic             steady;
   int               errors;
   int               voxels_sent;
   int               verts_checked;
   int               settings_used;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      steady = 1'b0;
      voxel_bus.valid = 1'b0;
      voxel_bus.block_type = '0;
      voxel_bus.local_x = '0;
      voxel_bus.local_y = '0;
      voxel_bus.local_z = '0;
      voxel_bus.air_neighbors = '0;
      vertex_bus.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected vertex words for one voxel, in face then vertex order
   function automatic void mesh_voxel(input voxel_type vx);
      logic [TEX_W-1:0] packed_tex;
      tex_idx_type      tile;
      logic [2:0]       col;
      logic [2:0]       row;
      logic [2:0]       c;
      logic [1:0]       uv;
      vertex_type       vt;
      int               count;
      count = 0;
      if (vx.kind == BT_AIR) begin
         return;
      end
      packed_tex = tex_bank[vx.kind - 1];
      for (int f = 0; f < NUM_FACES; f++) begin
         if (vx.open_faces[f]) begin
            if (face_type'(f) == FACE_TOP) begin
               tile = packed_tex[7:4];
            end else if (face_type'(f) == FACE_BOTTOM) begin
               tile = packed_tex[11:8];
            end else begin
               tile = packed_tex[3:0];
            end
            col = 3'(tile % ATLAS_TILES);
            row = 3'(tile / ATLAS_TILES);
            for (int n = 0; n < NUM_VERTS; n++) begin
               c = CUBE_CORNER[f][n];
               uv = TILE_CORNER[n];
               vt.x = 5'(vx.x) + 5'(c[2]);
               vt.y = 8'(vx.y) + 8'(c[1]);
               vt.z = 5'(vx.z) + 5'(c[0]);
               vt.u = col + 3'(uv[1]);
               vt.v = row + 3'(uv[0]);
               vt.face = face_type'(f);
               vt.last = 1'b0;
               expected_verts.insert(expected_verts.size(), vt);
               count++;
            end
         end
      end
      if (count > 0) begin
         expected_verts[$].last = 1'b1;
      end
   endfunction

   // voxel driver
   always @(posedge clock) begin
      if (reset) begin
         voxel_bus.valid <= 1'b0;
      end else begin
         if (voxel_bus.valid && voxel_bus.ready) begin
            mesh_voxel(voxel_on_bus);
            voxels_sent++;
         end
         if (!voxel_bus.valid || voxel_bus.ready) begin
            if (pending_voxels.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
               voxel_on_bus = pending_voxels.pop_front();
               voxel_bus.valid <= 1'b1;
               voxel_bus.block_type <= voxel_on_bus.kind;
               voxel_bus.local_x <= voxel_on_bus.x;
               voxel_bus.local_y <= voxel_on_bus.y;
               voxel_bus.local_z <= voxel_on_bus.z;
               voxel_bus.air_neighbors <= voxel_on_bus.open_faces;
            end else begin
               voxel_bus.valid <= 1'b0;
            end
         end
      end
   end

   // vertex sink back-pressure
   always @(posedge clock) begin
      if (reset) begin
         vertex_bus.ready <= 1'b0;
      end else begin
         vertex_bus.ready <= steady || ($urandom_range(99) >= 20);
      end
   end

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         errors++;
      end
   endfunction

   // vertex monitor
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && vertex_bus.valid && vertex_bus.ready) begin
         if (expected_verts.size() == 0) begin
            $display("%0t: unexpected vertex word, expected none, actual x=%0d y=%0d z=%0d",
                     $realtime, vertex_bus.vert_x, vertex_bus.vert_y, vertex_bus.vert_z);
            errors++;
         end else begin
            want = expected_verts.pop_front();
            compare_field("vert_x", want.x, vertex_bus.vert_x);
            compare_field("vert_y", want.y, vertex_bus.vert_y);
            compare_field("vert_z", want.z, vertex_bus.vert_z);
            compare_field("tex_u", want.u, vertex_bus.tex_u);
            compare_field("tex_v", want.v, vertex_bus.tex_v);
            compare_field("face_index", want.face, vertex_bus.face_index);
            compare_field("last_vertex", want.last, vertex_bus.last_vertex);
            verts_checked++;
         end
      end
   end

   task automatic csr_access(input int idx, input logic wr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= ADDR_W'(4 * idx);
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (wr) begin
         if (idx < TEX_REGS) begin
            tex_bank[idx] = data[TEX_W-1:0];
         end
      end else if (prdata !== 32'(tex_bank[idx])) begin
         $display("%0t: texture register %0d readback, expected %0h, actual %0h",
                  $realtime, idx, tex_bank[idx], prdata);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic read_back_bank();
      for (int i = 0; i < TEX_REGS; i++) begin
         csr_access(i, 1'b0, '0);
      end
   endtask

   task automatic queue_voxel(input btype_type kind, input int x, input int y, input int z,
                              input face_mask_type mask);
      voxel_type vx;
      vx.kind = kind;
      vx.x = coord_x_type'(x);
      vx.y = coord_y_type'(y);
      vx.z = coord_z_type'(z);
      vx.open_faces = mask;
      pending_voxels.insert(pending_voxels.size(), vx);
   endtask

   function automatic voxel_type random_voxel();
      voxel_type vx;
      int        pick;
      vx.kind = ($urandom_range(9) == 0) ? BT_AIR : btype_type'($urandom_range(7, 1));
      pick = $urandom_range(9);
      vx.open_faces = (pick == 0) ? '0 : (pick == 1) ? '1 : face_mask_type'($urandom);
      if ($urandom_range(6) == 0) begin
         vx.x = $urandom_range(1) ? '1 : '0;
         vx.y = $urandom_range(1) ? '1 : '0;
         vx.z = $urandom_range(1) ? '1 : '0;
      end else begin
         vx.x = coord_x_type'($urandom);
         vx.y = coord_y_type'($urandom);
         vx.z = coord_z_type'($urandom);
      end
      return vx;
   endfunction

   // wait for the mesher to go quiet before touching the registers
   task automatic drain();
      while (pending_voxels.size() > 0 || voxel_bus.valid || expected_verts.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] setting;
      errors = 0;
      voxels_sent = 0;
      verts_checked = 0;
      settings_used = 1;
      for (int i = 0; i < TEX_REGS; i++) begin
         tex_bank[i] = TEX_DEFAULTS[i];
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      read_back_bank();

      // directed voxels under the reset textures
      queue_voxel(BT_AIR, 0, 0, 0, '1);
      queue_voxel(BT_AIR, 15, 127, 15, '0);
      for (int k = 1; k <= 7; k++) begin
         queue_voxel(btype_type'(k), (k % 2) ? 15 : 0, (k % 2) ? 127 : 0,
                     (k % 2) ? 15 : 0, '1);
      end
      queue_voxel(KIND_STONE, 7, 64, 8, '0);
      for (int f = 0; f < NUM_FACES; f++) begin
         queue_voxel(btype_type'(f + 1), $urandom_range(15), $urandom_range(127),
                     $urandom_range(15), face_mask_type'(1 << f));
      end
      queue_voxel(KIND_WATER, 0, 127, 15, 6'b101010);
      queue_voxel(KIND_LOG, 15, 0, 0, 6'b010101);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int i = 0; i < TEX_REGS; i++) begin
            case (phase)
               0: setting = '1;
               1: setting = '0;
               default: setting = $urandom;
            endcase
            csr_access(i, 1'b1, setting);
         end
         csr_access(REG_SPARE, 1'b1, $urandom);
         read_back_bank();
         settings_used++;
         steady <= (phase == 2);
         for (int n = 0; n < PHASE_VOXELS; n++) begin
            pending_voxels.insert(pending_voxels.size(), random_voxel());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d voxels and %0d vertex words over %0d texture settings",
               voxels_sent, verts_checked, settings_used);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d vertex words still expected", expected_verts.size());
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
